// File: rtl/fesp_pkg.sv
// Shared types and constants for the flash erase size planner.
// Holds the input and result beat structs, status and operation codes,
// and register indexes. No dependencies.
package fesp_pkg;

    localparam int ADDR_W       = 24;
    localparam int COUNT_W      = 16;
    localparam int OPC_W        = 8;
    localparam int COVER_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int SECTOR_SHIFT = 12;

    // Operation codes of an input beat.
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_DONE    = 1'b1;

    // Status codes of a result beat.
    localparam logic [STATUS_W-1:0] ST_ISSUE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FINISHED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY       = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OPC_4K  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPC_32K = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPC_64K = 2'd2;

    localparam logic [OPC_W-1:0] OPC_4K_RESET  = 8'h20;
    localparam logic [OPC_W-1:0] OPC_32K_RESET = 8'h00;
    localparam logic [OPC_W-1:0] OPC_64K_RESET = 8'h00;

    // Sectors covered by each erase size.
    localparam logic [COVER_W-1:0] CHUNK_4K  = 5'd1;
    localparam logic [COVER_W-1:0] CHUNK_32K = 5'd8;
    localparam logic [COVER_W-1:0] CHUNK_64K = 5'd16;

    typedef struct packed {
        logic               operation;
        logic [ADDR_W-1:0]  start_address;
        logic [COUNT_W-1:0] sector_count;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OPC_W-1:0]    erase_opcode;
        logic [ADDR_W-1:0]   erase_address;
        logic [COVER_W-1:0]  sectors_covered;
    } t_out_beat;

    typedef struct packed {
        logic [OPC_W-1:0]   erase_opcode;
        logic [COVER_W-1:0] sectors;
    } t_chunk;

endpackage

// File: rtl/fesp_size_select.sv
// Erase size selection for the flash erase size planner.
// Picks the largest erase that fits the position and remaining count.
// Depends on fesp_pkg.
module fesp_size_select (
    input  logic [fesp_pkg::ADDR_W-1:0]  i_addr,
    input  logic [fesp_pkg::COUNT_W-1:0] i_left,
    input  logic [fesp_pkg::OPC_W-1:0]   i_opc_4k,
    input  logic [fesp_pkg::OPC_W-1:0]   i_opc_32k,
    input  logic [fesp_pkg::OPC_W-1:0]   i_opc_64k,
    output fesp_pkg::t_chunk             o_chunk
);
    import fesp_pkg::*;

    logic fit_64k;
    logic fit_32k;

    assign fit_64k = (i_left >= COUNT_W'(CHUNK_64K)) && (i_addr[15:0] == '0)
                     && (i_opc_64k != '0);
    assign fit_32k = (i_left >= COUNT_W'(CHUNK_32K)) && (i_addr[14:0] == '0)
                     && (i_opc_32k != '0);

    always_comb begin
        if (fit_64k) begin
            o_chunk.erase_opcode = i_opc_64k;
            o_chunk.sectors      = CHUNK_64K;
        end else if (fit_32k) begin
            o_chunk.erase_opcode = i_opc_32k;
            o_chunk.sectors      = CHUNK_32K;
        end else begin
            o_chunk.erase_opcode = i_opc_4k;
            o_chunk.sectors      = CHUNK_4K;
        end
    end

endmodule

// File: rtl/flash_erase_size_planner_unit.sv
// Top level of the flash erase size planner.
// Holds plan state, opcode registers and the result output stage.
// Depends on fesp_pkg and fesp_size_select.

// The planner takes one beat per clock cycle while input ready is high: a
// new erase request or the completion of the command last issued. Each
// accepted beat is handled in the cycle it is accepted, by one address add,
// one count subtract and the size compares, and its result (if it has one)
// is registered at that same edge, in the output register or the skid
// register. A two-entry output stage (output register plus skid register)
// decouples the sides: input ready depends only on the skid register, so a
// beat is taken while an earlier result waits, and sustained throughput is
// one beat per cycle whenever the consumer keeps taking results. A done beat
// while idle makes no result. Opcode registers are written through the plain
// write port and should only change while the planner is idle.
module flash_erase_size_planner_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  fesp_pkg::t_in_beat             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output fesp_pkg::t_out_beat            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [fesp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fesp_pkg::OPC_W-1:0]     i_cfg_data
);
    import fesp_pkg::*;

    // Opcode registers.
    logic [OPC_W-1:0] r_opc_4k;
    logic [OPC_W-1:0] r_opc_32k;
    logic [OPC_W-1:0] r_opc_64k;

    // Plan state.
    logic               r_busy,  n_busy;
    logic [ADDR_W-1:0]  r_addr,  n_addr;
    logic [COUNT_W-1:0] r_left,  n_left;
    logic [COVER_W-1:0] r_chunk, n_chunk;

    // Output register and skid register.
    logic      r_out_valid;
    t_out_beat r_out;
    logic      r_skid_valid;
    t_out_beat r_skid;

    logic               accept;
    logic               res_valid;
    t_out_beat          res;
    logic [ADDR_W-1:0]  adv_addr;
    logic [COUNT_W-1:0] adv_left;
    logic [ADDR_W-1:0]  sel_addr;
    logic [COUNT_W-1:0] sel_left;
    t_chunk             chunk;
    logic               out_free;

    assign o_in_ready  = ~r_skid_valid;
    assign accept      = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The address wraps at 24 bits; the count saturates at zero.
    assign adv_addr = r_addr + {{(ADDR_W - COVER_W - SECTOR_SHIFT){1'b0}}, r_chunk,
                                {SECTOR_SHIFT{1'b0}}};
    assign adv_left = (r_left >= COUNT_W'(r_chunk)) ? (r_left - COUNT_W'(r_chunk)) : '0;

    // One selector serves both the first command of a plan and later ones.
    assign sel_addr = (i_in_data.operation == OP_DONE) ? adv_addr : i_in_data.start_address;
    assign sel_left = (i_in_data.operation == OP_DONE) ? adv_left : i_in_data.sector_count;

    fesp_size_select u_size_select (
        .i_addr    (sel_addr),
        .i_left    (sel_left),
        .i_opc_4k  (r_opc_4k),
        .i_opc_32k (r_opc_32k),
        .i_opc_64k (r_opc_64k),
        .o_chunk   (chunk)
    );

    always_comb begin
        n_busy    = r_busy;
        n_addr    = r_addr;
        n_left    = r_left;
        n_chunk   = r_chunk;
        res_valid = 1'b0;
        res       = '0;
        if (i_in_data.operation == OP_REQUEST) begin
            res_valid = 1'b1;
            if (r_busy) begin
                res.status = ST_BUSY;
            end else if (i_in_data.start_address[SECTOR_SHIFT-1:0] != '0) begin
                res.status = ST_MISALIGNED;
            end else if (i_in_data.sector_count == '0) begin
                res.status = ST_FINISHED;
            end else begin
                n_busy              = 1'b1;
                n_addr              = i_in_data.start_address;
                n_left              = i_in_data.sector_count;
                n_chunk             = chunk.sectors;
                res.status          = ST_ISSUE;
                res.erase_opcode    = chunk.erase_opcode;
                res.erase_address   = i_in_data.start_address;
                res.sectors_covered = chunk.sectors;
            end
        end else if (r_busy) begin
            res_valid = 1'b1;
            n_addr    = adv_addr;
            n_left    = adv_left;
            if (adv_left == '0) begin
                n_busy     = 1'b0;
                n_chunk    = '0;
                res.status = ST_FINISHED;
            end else begin
                n_chunk             = chunk.sectors;
                res.status          = ST_ISSUE;
                res.erase_opcode    = chunk.erase_opcode;
                res.erase_address   = adv_addr;
                res.sectors_covered = chunk.sectors;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opc_4k  <= OPC_4K_RESET;
            r_opc_32k <= OPC_32K_RESET;
            r_opc_64k <= OPC_64K_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OPC_4K:  r_opc_4k  <= i_cfg_data;
                CFG_OPC_32K: r_opc_32k <= i_cfg_data;
                CFG_OPC_64K: r_opc_64k <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_addr  <= '0;
            r_left  <= '0;
            r_chunk <= '0;
        end else if (accept) begin
            r_busy  <= n_busy;
            r_addr  <= n_addr;
            r_left  <= n_left;
            r_chunk <= n_chunk;
        end
    end

    // The output register can load when it is empty or being taken.
    assign out_free = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept & res_valid;
            end
        end else if (accept & res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept & res_valid) begin
                r_out <= res;
            end
        end else if (accept & res_valid) begin
            r_skid <= res;
        end
    end

    // The skid register only fills while the output register is held.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // A plan in progress always has a command in flight and sectors left.
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_chunk != '0) && (r_left != '0))
        else $error("busy with no command in flight or no sectors left");

    // When idle, no command is in flight.
    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_chunk == '0))
        else $error("idle with a command still in flight");

    // An issued command covers one of the three erase sizes.
    a_issue_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_ISSUE)) |->
        ((o_out_data.sectors_covered == CHUNK_4K) ||
         (o_out_data.sectors_covered == CHUNK_32K) ||
         (o_out_data.sectors_covered == CHUNK_64K)))
        else $error("issued command with an invalid erase size");

endmodule

// File: tb/fesp_checker.sv
// Scoreboard for the flash erase size planner: watches both beat channels and
// the register write port, predicts each result and compares it field by field.
// Depends on fesp_pkg for the beat structs, codes and widths.
module fesp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  fesp_pkg::t_in_beat             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  fesp_pkg::t_out_beat            i_out_data,
    input  logic                           i_cfg_we,
    input  logic [fesp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fesp_pkg::OPC_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output logic                           o_plan_busy
);
    timeunit 1ns;
    timeprecision 1ps;
    import fesp_pkg::*;

    // Shadow copy of the opcode registers and of the plan in progress.
    logic [OPC_W-1:0]   opc_4k = OPC_4K_RESET;
    logic [OPC_W-1:0]   opc_32k = OPC_32K_RESET;
    logic [OPC_W-1:0]   opc_64k = OPC_64K_RESET;
    logic               plan_busy = 1'b0;
    logic [ADDR_W-1:0]  cur_addr = '0;
    logic [COUNT_W-1:0] sectors_left = '0;
    logic [COVER_W-1:0] chunk = '0;

    t_out_beat expected_results[$];
    int        fail_count = 0;
    int        pending_n = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;
    assign o_plan_busy  = plan_busy;

    // Largest erase that fits at the given address with the given sectors left.
    function automatic t_chunk choose_chunk(input logic [ADDR_W-1:0] addr,
                                            input logic [COUNT_W-1:0] remaining);
        t_chunk ck;
        if (remaining >= COUNT_W'(CHUNK_64K) && addr[15:0] == '0 && opc_64k != '0) begin
            ck.erase_opcode = opc_64k;
            ck.sectors      = CHUNK_64K;
        end else if (remaining >= COUNT_W'(CHUNK_32K) && addr[14:0] == '0
                     && opc_32k != '0) begin
            ck.erase_opcode = opc_32k;
            ck.sectors      = CHUNK_32K;
        end else begin
            ck.erase_opcode = opc_4k;
            ck.sectors      = CHUNK_4K;
        end
        return ck;
    endfunction

    function automatic t_out_beat status_only(input logic [STATUS_W-1:0] st);
        t_out_beat b;
        b = '0;
        b.status = st;
        return b;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat want;
        t_in_beat  beat;
        t_chunk    ck;
        logic      has_result;
        logic      issue;
        if (!i_rst_n) begin
            opc_4k       = OPC_4K_RESET;
            opc_32k      = OPC_32K_RESET;
            opc_64k      = OPC_64K_RESET;
            plan_busy    = 1'b0;
            cur_addr     = '0;
            sectors_left = '0;
            chunk        = '0;
            expected_results.delete();
        end else begin
            // Results first: a result leaving at this edge belongs to an
            // earlier input beat, never to one accepted at the same edge.
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting: %p", got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.erase_opcode !== want.erase_opcode) begin
                        $error("erase_opcode: expected %02h, got %02h",
                               want.erase_opcode, got.erase_opcode);
                        fail_count++;
                    end
                    if (got.erase_address !== want.erase_address) begin
                        $error("erase_address: expected %06h, got %06h",
                               want.erase_address, got.erase_address);
                        fail_count++;
                    end
                    if (got.sectors_covered !== want.sectors_covered) begin
                        $error("sectors_covered: expected %0d, got %0d",
                               want.sectors_covered, got.sectors_covered);
                        fail_count++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OPC_4K:  opc_4k  = i_cfg_data;
                    CFG_OPC_32K: opc_32k = i_cfg_data;
                    CFG_OPC_64K: opc_64k = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                beat       = i_in_data;
                has_result = 1'b0;
                issue      = 1'b0;
                want       = '0;
                if (beat.operation == OP_REQUEST) begin
                    has_result = 1'b1;
                    if (plan_busy) begin
                        want = status_only(ST_BUSY);
                    end else if (beat.start_address[SECTOR_SHIFT-1:0] != '0) begin
                        want = status_only(ST_MISALIGNED);
                    end else if (beat.sector_count == '0) begin
                        want = status_only(ST_FINISHED);
                    end else begin
                        plan_busy    = 1'b1;
                        cur_addr     = beat.start_address;
                        sectors_left = beat.sector_count;
                        issue        = 1'b1;
                    end
                end else if (plan_busy) begin
                    // The address wraps at 24 bits by the width of cur_addr.
                    has_result   = 1'b1;
                    cur_addr     = cur_addr + (ADDR_W'(chunk) << SECTOR_SHIFT);
                    sectors_left = (sectors_left >= COUNT_W'(chunk))
                                   ? sectors_left - COUNT_W'(chunk) : '0;
                    if (sectors_left == '0) begin
                        plan_busy = 1'b0;
                        chunk     = '0;
                        want      = status_only(ST_FINISHED);
                    end else begin
                        issue = 1'b1;
                    end
                end
                if (issue) begin
                    ck    = choose_chunk(cur_addr, sectors_left);
                    chunk = ck.sectors;
                    want  = '{status: ST_ISSUE, erase_opcode: ck.erase_opcode,
                              erase_address: cur_addr, sectors_covered: ck.sectors};
                end
                if (has_result) begin
                    expected_results.push_back(want);
                end
            end
        end
        pending_n = expected_results.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the flash erase size planner testbench: clock, reset, stimulus for
// the request channel and the register port, and the result-side consumer.
// Depends on fesp_pkg, fesp_checker and flash_erase_size_planner_unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fesp_pkg::*;

    // Every input of the block has a known value from time zero.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_beat             in_data = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_OPC_4K;
    logic [OPC_W-1:0]     cfg_data = '0;

    logic      in_ready;
    logic      out_valid;
    t_out_beat out_data;

    int   fail_count;
    int   pending;
    logic plan_busy;

    // Flags shared by the stimulus and the consumer. A burst flag removes
    // the random gaps on its side; long_hold asks the consumer for one long
    // stretch with ready low, which fills the output stage and stalls input.
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    logic long_hold = 1'b0;
    int   beats_sent = 0;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;

    flash_erase_size_planner_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    fesp_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_plan_busy  (plan_busy)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // A run that goes on far longer than the slowest correct run is called hung.
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_in_beat make_request(input logic [ADDR_W-1:0] addr,
                                              input logic [COUNT_W-1:0] count);
        return '{operation: OP_REQUEST, start_address: addr, sector_count: count};
    endfunction

    // The address and count of a done beat are ignored, so they are random.
    function automatic t_in_beat make_done();
        return '{operation: OP_DONE, start_address: ADDR_W'($urandom),
                 sector_count: COUNT_W'($urandom)};
    endfunction

    function automatic t_in_beat make_misaligned();
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'($urandom);
        if (addr[SECTOR_SHIFT-1:0] == '0) begin
            addr[$urandom_range(0, SECTOR_SHIFT - 1)] = 1'b1;
        end
        return make_request(addr, COUNT_W'($urandom));
    endfunction

    // Sector-aligned start addresses, biased toward 64 KiB and 32 KiB
    // boundaries and toward the top of the address space so plans wrap.
    function automatic logic [ADDR_W-1:0] aligned_addr();
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'($urandom);
        case ($urandom_range(0, 3))
            0: addr[15:0] = '0;
            1: addr[14:0] = '0;
            2: addr[11:0] = '0;
            default: addr = 24'hFF0000 | ADDR_W'($urandom_range(0, 15) << SECTOR_SHIFT);
        endcase
        return addr;
    endfunction

    // Mostly short plans so each one needs a handful of done beats.
    function automatic logic [COUNT_W-1:0] plan_count();
        if ($urandom_range(0, 19) == 0) begin
            return COUNT_W'($urandom_range(41, 300));
        end
        return COUNT_W'($urandom_range(1, 40));
    endfunction

    // Offers one beat and returns at the falling edge after it is accepted.
    // Valid stays high across back-to-back beats, so it never drops between
    // them. A done beat while idle is not counted, since the block ignores it.
    task automatic send_beat(input t_in_beat beat);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (beat.operation == OP_REQUEST || plan_busy) begin
            beats_sent++;
        end
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = beat;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Waits until every expected result has arrived, and waits on after that
    // in case the last beat was a done while idle still being processed.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_opcodes(input logic [OPC_W-1:0] op4k,
                               input logic [OPC_W-1:0] op32k,
                               input logic [OPC_W-1:0] op64k);
        logic [CFG_IDX_W-1:0] idx_list[3];
        logic [OPC_W-1:0]     val_list[3];
        idx_list = '{CFG_OPC_4K, CFG_OPC_32K, CFG_OPC_64K};
        val_list = '{op4k, op32k, op64k};
        wait_idle();
        for (int i = 0; i < 3; i++) begin
            cfg_we   = 1'b1;
            cfg_idx  = idx_list[i];
            cfg_data = val_list[i];
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    // One well-formed plan: a request, then done beats until the planner
    // reports finished, with an occasional request thrown in while it is busy.
    task automatic run_plan();
        send_beat(make_request(aligned_addr(), plan_count()));
        while (plan_busy) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(make_request(ADDR_W'($urandom), COUNT_W'($urandom)));
            end else begin
                send_beat(make_done());
            end
        end
    endtask

    task automatic run_random(input int n_beats);
        int stop_at;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            // Every so often switch the idling pattern on both sides.
            if ($urandom_range(0, 9) == 0) begin
                tx_burst = ($urandom_range(0, 2) == 0);
                rx_burst = ($urandom_range(0, 2) == 0);
            end
            case ($urandom_range(0, 19))
                0, 1:    send_beat(make_misaligned());
                2:       send_beat(make_request(aligned_addr(), '0));
                3:       send_beat(make_done());
                default: run_plan();
            endcase
        end
    endtask

    // Result consumer. Ready is dropped for a random number of cycles before
    // each beat, except in burst stretches, and once for a long hold-off.
    initial begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (long_hold) begin
                out_ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin
        int waited;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset opcodes: only 4 KiB erases exist.
        send_beat('{operation: OP_DONE, start_address: '1, sector_count: '1});
        send_beat(make_request(24'h000001, 16'd5));
        send_beat(make_request(24'hFFFFFF, 16'hFFFF));
        send_beat(make_request(24'h000000, 16'd0));
        // Two sectors at the top of the address space: the second one wraps.
        send_beat(make_request(24'hFFF000, 16'd2));
        send_beat(make_done());
        send_beat(make_done());

        // All three sizes enabled.
        set_opcodes(8'h20, 8'h52, 8'hD8);
        send_beat(make_request(24'hFF0000, 16'd25));
        send_beat(make_request(24'h000000, 16'hFFFF));
        send_beat(make_done());
        send_beat(make_done());
        send_beat(make_done());
        // A 32 KiB boundary that is not a 64 KiB boundary.
        send_beat(make_request(24'h008000, 16'd16));
        send_beat(make_done());
        send_beat(make_done());

        // Extreme opcode values, including a zero 4 KiB opcode.
        set_opcodes(8'h00, 8'hFF, 8'hFF);
        send_beat(make_request(24'h7FF000, 16'd1));
        send_beat(make_done());
        send_beat(make_request(24'h800000, 16'd16));
        send_beat(make_done());

        // Random part. The first phase opens with back-to-back beats against
        // a consumer that holds off, so the block has to stall its input.
        set_opcodes(8'h20, 8'h52, 8'hD8);
        tx_burst  = 1'b1;
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_beat(make_misaligned());
        end
        tx_burst = 1'b0;
        run_random(130);

        set_opcodes(8'h20, 8'h00, 8'hD8);
        run_random(140);

        set_opcodes(8'hFF, 8'h01, 8'h00);
        run_random(140);

        set_opcodes(OPC_W'($urandom_range(0, 255)), OPC_W'($urandom_range(1, 255)),
                    OPC_W'($urandom_range(1, 255)));
        run_random(140);

        // Drain: each result is registered when its beat is accepted, so a short wait
        // after the last expectation is met is enough to catch extra beats.
        in_valid = 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
